[hw/rtl/gfp_pkg.sv]
package gfp_pkg;

  // Default width of the frame byte position counter.
  localparam int unsigned FramePosBits = 16;

  // Default depth of the queue between the parser and the result stage.
  localparam int unsigned QueueDepth = 4;

  // Reset value of the frame header length register.
  localparam logic [7:0] FrameHeaderReset = 8'd10;

  // Register index of the frame header length register.
  localparam logic RegFrameHeader = 1'b0;

  // GSE mode codes.
  localparam logic [1:0] ModeGuarantee = 2'd1;
  localparam logic [1:0] ModeCrypto    = 2'd3;

  // Result kinds.
  localparam logic KindDescriptor = 1'b0;
  localparam logic KindSummary    = 1'b1;

  // Parse phases of the byte stream.
  typedef enum logic [2:0] {
    PH_FHDR   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_BODY   = 3'd3,
    PH_PRE    = 3'd4,
    PH_CHI    = 3'd5,
    PH_CLO    = 3'd6,
    PH_PAD    = 3'd7
  } phase_e;

  // Everything that one accepted byte causes: a descriptor, a summary or both.
  typedef struct packed {
    logic        desc_valid;
    logic        sum_valid;
    logic [11:0] data_length;
    logic [13:0] header_bytes;
    logic [11:0] payload_bytes;
    logic        start_flag;
    logic        end_flag;
    logic [1:0]  mode;
    logic        payload_clamped;
    logic [15:0] padding_count;
    logic [15:0] packet_count;
    logic        truncated;
  } event_t;

  // Header length before the guarantee and crypto fields.
  function automatic logic [2:0] base_header(input logic [7:0] b1);
    logic [2:0] h;
    h = 3'd2;
    if (b1[7] != b1[6]) h = h + 3'd1;
    if (b1[7]) h = h + 3'd2;
    return h;
  endfunction

endpackage

[hw/rtl/gfp_in_if.sv]
interface gfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/gfp_out_if.sv]
interface gfp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] data_length;
  logic [13:0] header_bytes;
  logic [11:0] payload_bytes;
  logic        start_flag;
  logic        end_flag;
  logic [1:0]  mode;
  logic        payload_clamped;
  logic [15:0] padding_count;
  logic [15:0] packet_count;
  logic        truncated;
  logic        last_result;

  modport source (
    output valid, output kind, output data_length, output header_bytes,
    output payload_bytes, output start_flag, output end_flag, output mode,
    output payload_clamped, output padding_count, output packet_count,
    output truncated, output last_result, input ready
  );
  modport sink (
    input valid, input kind, input data_length, input header_bytes,
    input payload_bytes, input start_flag, input end_flag, input mode,
    input payload_clamped, input padding_count, input packet_count,
    input truncated, input last_result, output ready
  );
endinterface

[hw/rtl/gfp_front.sv]
module gfp_front import gfp_pkg::*; #(
  parameter int unsigned FRAME_POS_BITS = FramePosBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  frame_header_bytes_i,
  gfp_in_if.sink      in_bus,
  input  logic        queue_ready_i,
  output logic        push_o,
  output event_t      event_o
);

  logic [FRAME_POS_BITS-1:0] pos_q, pos_d, pos_inc, fhb_ext;
  phase_e      phase_q, phase_d, work;
  logic [7:0]  first_q, first_d;
  logic [11:0] len_q, len_d;
  logic [13:0] skip_q, skip_d;
  logic [7:0]  chi_q, chi_d;
  logic [15:0] pad_q, pad_d;
  logic [15:0] pkt_q, pkt_d;

  logic        in_fire;
  logic        parse;
  logic        lone;
  logic        desc;
  logic [1:0]  pad_add;
  logic [16:0] pad_sum;
  logic [13:0] hdr;
  logic [2:0]  base;
  logic [12:0] reserved;
  logic [11:0] body_len;
  logic [15:0] pay;
  logic [1:0]  mode_new;

  // Accept a byte whenever the queue has room for what it may cause.
  assign in_bus.ready = queue_ready_i;
  assign in_fire      = in_bus.valid && queue_ready_i;

  assign pos_inc = (pos_q != '1) ? pos_q + FRAME_POS_BITS'(1) : pos_q;
  assign fhb_ext = FRAME_POS_BITS'(frame_header_bytes_i);

  // Parse one byte and work out the state after it.
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    first_d  = first_q;
    len_d    = len_q;
    skip_d   = skip_q;
    chi_d    = chi_q;
    pad_d    = pad_q;
    pkt_d    = pkt_q;
    work     = phase_q;
    parse    = 1'b0;
    lone     = 1'b0;
    desc     = 1'b0;
    pad_add  = 2'd0;
    pad_sum  = 17'd0;
    hdr      = 14'd0;
    base     = base_header(first_q);
    reserved = 13'd0;
    body_len = 12'd0;
    pay      = 16'd0;
    mode_new = first_q[5:4];
    push_o   = 1'b0;
    event_o  = '0;

    if (in_fire) begin
      pos_d = pos_inc;
      parse = 1'b1;
      if (phase_q == PH_FHDR) begin
        if (pos_q < fhb_ext) begin
          parse = 1'b0;
          if (pos_inc >= fhb_ext) phase_d = PH_FIRST;
        end else begin
          work = PH_FIRST;
        end
      end

      if (parse) begin
        case (work)
          PH_FIRST: begin
            if (in_bus.last_byte) begin
              pad_add = 2'd1;
              lone    = 1'b1;
            end else begin
              first_d = in_bus.data_byte;
              phase_d = PH_SECOND;
            end
          end
          PH_SECOND: begin
            if (first_q == 8'd0 && in_bus.data_byte == 8'd0) begin
              pad_add = 2'd2;
              phase_d = PH_PAD;
            end else begin
              len_d = {first_q[3:0], in_bus.data_byte};
              if (mode_new == ModeCrypto) begin
                skip_d  = {11'd0, base} + 14'd2;
                phase_d = PH_PRE;
              end else begin
                hdr = {11'd0, base};
                if (mode_new == ModeGuarantee) hdr = hdr + 14'd4;
                desc    = 1'b1;
                skip_d  = {2'd0, len_d};
                phase_d = (skip_d != 14'd0) ? PH_BODY : PH_FIRST;
              end
            end
          end
          PH_BODY: begin
            skip_d = skip_q - 14'd1;
            if (skip_d == 14'd0) phase_d = PH_FIRST;
          end
          PH_PRE: begin
            skip_d = skip_q - 14'd1;
            if (skip_d == 14'd0) phase_d = PH_CHI;
          end
          PH_CHI: begin
            chi_d   = in_bus.data_byte;
            phase_d = PH_CLO;
          end
          PH_CLO: begin
            reserved = {chi_q[4:0], in_bus.data_byte};
            hdr      = {11'd0, base} + 14'd6 + {1'b0, reserved};
            desc     = 1'b1;
            if (len_q > ({9'd0, base} + 12'd4)) begin
              body_len = len_q - ({9'd0, base} + 12'd4);
            end
            skip_d  = {2'd0, body_len};
            phase_d = (skip_d != 14'd0) ? PH_BODY : PH_FIRST;
          end
          PH_PAD: begin
            pad_add = 2'd1;
          end
          default: begin
          end
        endcase
      end

      // Saturating frame counters.
      pad_sum = {1'b0, pad_q} + {15'd0, pad_add};
      pad_d   = pad_sum[16] ? 16'hFFFF : pad_sum[15:0];
      if (desc && pkt_q != 16'hFFFF) pkt_d = pkt_q + 16'd1;

      // Descriptor fields; the payload may come out negative.
      pay = {4'd0, len_d} - ({2'd0, hdr} - 16'd2);
      event_o.desc_valid      = desc;
      event_o.data_length     = desc ? len_d : 12'd0;
      event_o.header_bytes    = hdr;
      event_o.payload_bytes   = pay[15] ? 12'd0 : pay[11:0];
      event_o.start_flag      = desc && first_d[7];
      event_o.end_flag        = desc && first_d[6];
      event_o.mode            = desc ? first_d[5:4] : 2'd0;
      event_o.payload_clamped = desc && pay[15];

      // The final byte of a frame closes it with a summary.
      if (in_bus.last_byte) begin
        event_o.sum_valid     = 1'b1;
        event_o.padding_count = pad_d;
        event_o.packet_count  = pkt_d;
        event_o.truncated     = !lone && phase_d != PH_FIRST && phase_d != PH_PAD;
        pos_d   = '0;
        phase_d = PH_FHDR;
        first_d = 8'd0;
        len_d   = 12'd0;
        skip_d  = 14'd0;
        chi_d   = 8'd0;
        pad_d   = 16'd0;
        pkt_d   = 16'd0;
      end

      push_o = desc || in_bus.last_byte;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_FHDR;
      first_q <= 8'd0;
      len_q   <= 12'd0;
      skip_q  <= 14'd0;
      chi_q   <= 8'd0;
      pad_q   <= 16'd0;
      pkt_q   <= 16'd0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      first_q <= first_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      chi_q   <= chi_d;
      pad_q   <= pad_d;
      pkt_q   <= pkt_d;
    end
  end

`ifndef SYNTHESIS
  // A frame end brings the parser back to the frame header skip.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_bus.last_byte) |=> (pos_q == '0 && phase_q == PH_FHDR))
    else $error("parser state not cleared after frame end");

  // Descriptors come only from the second header byte or the crypto low byte.
  a_desc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.desc_valid |-> (phase_q == PH_SECOND || phase_q == PH_CLO ||
                            phase_q == PH_FHDR))
    else $error("descriptor raised in a phase that cannot complete a header");
`endif

endmodule

[hw/rtl/gfp_queue.sv]
module gfp_queue import gfp_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t push_data_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output event_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  event_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o    = (cnt_q != CntW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue fill count beyond depth");

  // A push into a full queue would drop a request.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o)
    else $error("push into a full queue");
`endif

endmodule

[hw/rtl/gfp_back.sv]
module gfp_back import gfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  event_t event_i,
  output logic   pop_o,
  gfp_out_if.source out_bus
);

  event_t ev_q;
  logic   pend_desc_q, pend_desc_d;
  logic   pend_sum_q, pend_sum_d;
  logic   fire;
  logic   rem_desc, rem_sum;

  assign fire     = out_bus.valid && out_bus.ready;
  assign rem_desc = pend_desc_q && !fire;
  assign rem_sum  = pend_sum_q && !(fire && !pend_desc_q);

  // Take the next entry as soon as the current one is fully delivered.
  assign pop_o = valid_i && !rem_desc && !rem_sum;

  always_comb begin
    pend_desc_d = rem_desc;
    pend_sum_d  = rem_sum;
    if (pop_o) begin
      pend_desc_d = event_i.desc_valid;
      pend_sum_d  = event_i.sum_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_desc_q <= 1'b0;
      pend_sum_q  <= 1'b0;
    end else begin
      pend_desc_q <= pend_desc_d;
      pend_sum_q  <= pend_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ev_q <= event_i;
  end

  // The descriptor goes first, then the summary.
  assign out_bus.valid           = pend_desc_q || pend_sum_q;
  assign out_bus.kind            = pend_desc_q ? KindDescriptor : KindSummary;
  assign out_bus.data_length     = pend_desc_q ? ev_q.data_length : 12'd0;
  assign out_bus.header_bytes    = pend_desc_q ? ev_q.header_bytes : 14'd0;
  assign out_bus.payload_bytes   = pend_desc_q ? ev_q.payload_bytes : 12'd0;
  assign out_bus.start_flag      = pend_desc_q && ev_q.start_flag;
  assign out_bus.end_flag        = pend_desc_q && ev_q.end_flag;
  assign out_bus.mode            = pend_desc_q ? ev_q.mode : 2'd0;
  assign out_bus.payload_clamped = pend_desc_q && ev_q.payload_clamped;
  assign out_bus.padding_count   = pend_desc_q ? 16'd0 : ev_q.padding_count;
  assign out_bus.packet_count    = pend_desc_q ? 16'd0 : ev_q.packet_count;
  assign out_bus.truncated       = !pend_desc_q && ev_q.truncated;
  assign out_bus.last_result     = pend_desc_q ? !pend_sum_q : 1'b1;

`ifndef SYNTHESIS
  // A stalled result keeps its pending set until it is taken.
  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_bus.valid && !out_bus.ready) |=> (pend_desc_q == $past(pend_desc_q) &&
                                           pend_sum_q == $past(pend_sum_q)))
    else $error("pending results changed while stalled");
`endif

endmodule

[hw/rtl/gse_frame_packet_parser.sv]
// Channel   Direction  Payload                                 Accepted when
// in_bus    sink       data_byte, last_byte                    valid && ready
// out_bus   source     kind .. last_result (result fields)     valid && ready
// APB       slave      frame_header_bytes at address 0         psel && penable && pwrite
//
// One byte is accepted per cycle while the queue has room; it is parsed in the cycle
// it is accepted. Results leave one per cycle while out_bus is ready, from a registered
// result stage behind a short queue. Input ready drops only when the queue is full, so
// stalls on the output side reach the input after the queue depth is used up.
// Reset is asynchronous and active low; no clearing pass is needed after it.
module gse_frame_packet_parser import gfp_pkg::*; #(
  parameter int unsigned FRAME_POS_BITS = FramePosBits,
  parameter int unsigned QUEUE_DEPTH    = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfp_in_if.sink      in_bus,
  gfp_out_if.source   out_bus,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [7:0] fhb_q;
  logic       reg_sel;
  logic       q_ready, q_push, q_valid, q_pop;
  event_t     q_in, q_out;

  // Configuration register.
  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[2] == RegFrameHeader);
  assign prdata_o = reg_sel ? {24'd0, fhb_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fhb_q <= FrameHeaderReset;
    end else if (psel_i && penable_i && pwrite_i && reg_sel) begin
      fhb_q <= pwdata_i[7:0];
    end
  end

  gfp_front #(
    .FRAME_POS_BITS(FRAME_POS_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_header_bytes_i(fhb_q),
    .in_bus              (in_bus),
    .queue_ready_i       (q_ready),
    .push_o              (q_push),
    .event_o             (q_in)
  );

  gfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_out)
  );

  gfp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .event_i(q_out),
    .pop_o  (q_pop),
    .out_bus(out_bus)
  );

endmodule
